// ===== hw/rtl/comparator_output_set_update_defines.svh =====
// Assertion macros shared by the RTL files.
`ifndef COMPARATOR_OUTPUT_SET_UPDATE_DEFINES_SVH
`define COMPARATOR_OUTPUT_SET_UPDATE_DEFINES_SVH

`ifndef ASSERT_OFF
// prop must hold at every clock edge outside reset
`define COSU_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");
// cond must never be true outside reset
`define COSU_ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
		else $error("forbidden condition seen");
`else
`define COSU_ASSERT(label, clk, rst_n, prop)
`define COSU_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

// ===== hw/rtl/cosu_pkg.sv =====
package cosu_pkg;

	localparam int CHANNELS   = 8;
	localparam int VEC_W      = 8;
	localparam int CH_W       = 3;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_W      = 3;
	// bitmap is split over cells by the upper bits of the mapped vector
	localparam int CELL_SEL_W = 4;
	localparam int CELLS      = 1 << CELL_SEL_W;
	localparam int SLOT_W     = VEC_W - CELL_SEL_W;
	localparam int CELL_BITS  = 1 << SLOT_W;

	typedef logic [VEC_W-1:0]      vec_t;
	typedef logic [CH_W-1:0]       ch_t;
	typedef logic [CELL_SEL_W-1:0] cell_sel_t;
	typedef logic [SLOT_W-1:0]     slot_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_UPPER = 1'b0,
		REG_LOWER = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		ch_t upper;
		ch_t lower;
	} cfg_t;

	// one item as it travels down the cell row
	typedef struct packed {
		logic valid;
		vec_t vec;
		logic last;
		logic changed;
		logic first;
	} token_t;

endpackage

// ===== hw/rtl/cosu_if.sv =====
interface cosu_in_if;
	logic          valid;
	logic          ready;
	cosu_pkg::vec_t vector_in;
	logic          class_last;

	modport source (output valid, output vector_in, output class_last, input ready);
	modport sink (input valid, input vector_in, input class_last, output ready);
endinterface

interface cosu_out_if;
	logic          valid;
	logic          ready;
	cosu_pkg::vec_t vector_out;
	logic          first_seen;
	logic          end_of_class;
	logic          class_changed;

	modport source (output valid, output vector_out, output first_seen,
		output end_of_class, output class_changed, input ready);
	modport sink (input valid, input vector_out, input first_seen,
		input end_of_class, input class_changed, output ready);
endinterface

// ===== hw/rtl/cosu_front.sv =====
`include "comparator_output_set_update_defines.svh"

module cosu_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic             in_valid,
	input  cosu_pkg::vec_t   vector_in,
	input  logic             class_last,
	input  cosu_pkg::cfg_t   cfg,
	output cosu_pkg::token_t tok_out
);
	import cosu_pkg::*;

	ch_t    hi;
	ch_t    lo;
	logic   pass;
	logic   swap;
	vec_t   mapped;
	logic   altered;
	logic   any_altered_q;
	token_t tok_q;

	always_comb begin
		if (cfg.upper < cfg.lower) begin
			hi = cfg.lower;
			lo = cfg.upper;
		end else begin
			hi = cfg.upper;
			lo = cfg.lower;
		end
		pass    = (hi == lo) || (int'(hi) >= CHANNELS);
		swap    = !pass && vector_in[hi] && !vector_in[lo];
		mapped  = swap ? (vector_in ^ ((vec_t'(1) << hi) | (vec_t'(1) << lo))) : vector_in;
		altered = (mapped != vector_in);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q         <= '0;
			any_altered_q <= 1'b0;
		end else if (advance) begin
			tok_q.valid   <= in_valid;
			tok_q.vec     <= mapped;
			tok_q.last    <= class_last;
			tok_q.changed <= class_last && (any_altered_q || altered);
			tok_q.first   <= 1'b0;
			if (in_valid) begin
				any_altered_q <= class_last ? 1'b0 : (any_altered_q || altered);
			end
		end
	end

	assign tok_out = tok_q;

	// the class flag only rides on the last item of a class
	`COSU_ASSERT_NEVER(a_changed_only_on_last, clk, arst_n,
		tok_q.valid && tok_q.changed && !tok_q.last)

endmodule

// ===== hw/rtl/cosu_cell.sv =====
`include "comparator_output_set_update_defines.svh"

module cosu_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  cosu_pkg::cell_sel_t cell_id,
	input  cosu_pkg::token_t    tok_in,
	output cosu_pkg::token_t    tok_out
);
	import cosu_pkg::*;

	logic [CELL_BITS-1:0] bits_q;
	token_t               tok_q;
	token_t               tok_nx;
	logic                 hit;
	slot_t                slot;

	assign slot = tok_in.vec[SLOT_W-1:0];
	assign hit  = tok_in.valid && (tok_in.vec[VEC_W-1:SLOT_W] == cell_id);

	always_comb begin
		tok_nx = tok_in;
		if (hit) begin
			tok_nx.first = !bits_q[slot];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q  <= '0;
			bits_q <= '0;
		end else if (advance) begin
			tok_q <= tok_nx;
			// lookup above uses the old slice, then the class is wiped
			if (tok_in.valid && tok_in.last) begin
				bits_q <= '0;
			end else if (hit) begin
				bits_q[slot] <= 1'b1;
			end
		end
	end

	assign tok_out = tok_q;

	`COSU_ASSERT(a_cleared_after_class, clk, arst_n,
		advance && tok_in.valid && tok_in.last |=> bits_q == '0)
	`COSU_ASSERT(a_hit_marks_slot, clk, arst_n,
		advance && hit && !tok_in.last |=> bits_q[$past(slot)] && !tok_q.first == $past(bits_q[slot]))

endmodule

// ===== hw/rtl/comparator_output_set_update.sv =====
// Comparator apply and output-set update for one weight class of binary vectors.
// items   : vector_in and class_last, transferred when valid and ready are high.
// results : vector_out, first_seen, end_of_class, class_changed, one per item,
//           transferred when valid and ready are high.
// cfg     : cfg_we writes cfg_data into register cfg_index (0 upper, 1 lower
//           channel); write only while no item is in flight.
// Each item passes a comparator stage, then a row of 16 cells that each own
// 16 bits of the 256-entry seen bitmap. The comparator stage and then each cell
// register the item in turn before its result is valid; one item is taken per
// cycle when results are taken. A stall on results freezes the whole row, and
// items.ready drops in the same cycle. Each cell clears its slice as the last
// item of a class passes it, so no clearing pass is needed between classes.
// Reset empties the row, clears the bitmap and the altered flag, and sets
// the comparator to channels 1 and 0.
module comparator_output_set_update (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [cosu_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cosu_pkg::CFG_W-1:0]     cfg_data,
	cosu_in_if.sink                      items,
	cosu_out_if.source                   results
);
	import cosu_pkg::*;

	cfg_t   cfg_q;
	logic   advance;
	token_t chain [CELLS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.upper <= ch_t'(1);
			cfg_q.lower <= ch_t'(0);
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_UPPER: cfg_q.upper <= cfg_data[CH_W-1:0];
				REG_LOWER: cfg_q.lower <= cfg_data[CH_W-1:0];
				default: ;
			endcase
		end
	end

	assign advance     = !chain[CELLS].valid || results.ready;
	assign items.ready = advance;

	cosu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.in_valid  (items.valid),
		.vector_in (items.vector_in),
		.class_last(items.class_last),
		.cfg       (cfg_q),
		.tok_out   (chain[0])
	);

	for (genvar g = 0; g < CELLS; g++) begin : g_cell
		cosu_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.advance(advance),
			.cell_id(cell_sel_t'(g)),
			.tok_in (chain[g]),
			.tok_out(chain[g+1])
		);
	end

	assign results.valid         = chain[CELLS].valid;
	assign results.vector_out    = chain[CELLS].vec;
	assign results.first_seen    = chain[CELLS].first;
	assign results.end_of_class  = chain[CELLS].last;
	assign results.class_changed = chain[CELLS].changed;

endmodule
